FILE: design/cbz_pkg.sv
// Shared constants and types for the cubic Bezier evaluator.
`timescale 1ns / 1ps
package cbz_pkg;

   localparam int CBZ_COORD_WIDTH = 24;
   localparam int CBZ_T_FRAC_BITS = 16;
   // Multiplicand slice width for the partial products inside each cell
   localparam int CBZ_CHUNK       = 24;
   localparam int CBZ_NUM_REGS    = 8;
   // Input register, three levels of three-stage cells, output register
   localparam int CBZ_STAGES      = 11;

   typedef enum logic [2:0] {
      REG_P0_X,
      REG_P0_Y,
      REG_P1_X,
      REG_P1_Y,
      REG_P2_X,
      REG_P2_Y,
      REG_P3_X,
      REG_P3_Y
   } csr_reg_type;

   typedef logic [CBZ_STAGES-1:0] stage_en_type;

endpackage

FILE: design/cbz_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface cbz_req_if #(
   parameter int T_W = 17
) ();
   logic           valid;
   logic           ready;
   logic [T_W-1:0] t_param;

   modport source (output valid, output t_param, input ready);
   modport sink   (input valid, input t_param, output ready);
endinterface

interface cbz_rsp_if #(
   parameter int COORD_W = 24
) ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W+2:0] slope_x;
   logic signed [COORD_W+2:0] slope_y;

   modport source (output valid, output point_x, output point_y, output slope_x,
                   output slope_y, input ready);
   modport sink   (input valid, input point_x, input point_y, input slope_x,
                   input slope_y, output ready);
endinterface

FILE: design/cbz_lerp_cell.sv
// One de Casteljau cell: y = a * 2^F + t * (b - a), three register stages.
`timescale 1ns / 1ps
module cbz_lerp_cell #(
   parameter int IN_W        = 24,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic [2:0]                        en,
   input  logic signed [IN_W-1:0]            a_val,
   input  logic signed [IN_W-1:0]            b_val,
   input  logic [T_FRAC_BITS:0]              t_in,
   output logic signed [IN_W+T_FRAC_BITS-1:0] y_val
);
   import cbz_pkg::*;

   localparam int DW  = IN_W + 1;
   localparam int NCH = (DW + CBZ_CHUNK - 1) / CBZ_CHUNK;
   localparam int PW  = NCH * CBZ_CHUNK;
   localparam int PPW = CBZ_CHUNK + T_FRAC_BITS + 2;
   localparam int SW  = PW + T_FRAC_BITS + 2;
   localparam int OW  = IN_W + T_FRAC_BITS;

   logic signed [DW-1:0]   diff_ff, diff_in;
   logic signed [IN_W-1:0] a1_ff;
   logic [T_FRAC_BITS:0]   t1_ff;
   logic signed [PPW-1:0]  pp_ff [NCH];
   logic signed [PPW-1:0]  pp_in [NCH];
   logic signed [IN_W-1:0] a2_ff;
   logic signed [OW-1:0]   y_ff, y_in;

   always_comb begin
      diff_in = DW'(b_val) - DW'(a_val);
   end

   // Slice the difference; only the top slice carries the sign
   always_comb begin
      logic signed [PW-1:0]  dpad;
      logic signed [PPW-1:0] ma;
      logic signed [PPW-1:0] mt;
      dpad = PW'(diff_ff);
      mt   = PPW'($signed({1'b0, t1_ff}));
      for (int k = 0; k < NCH; k++) begin
         if (k < NCH - 1) begin
            ma = PPW'($signed({1'b0, dpad[k*CBZ_CHUNK +: CBZ_CHUNK]}));
         end else begin
            ma = PPW'($signed(dpad[k*CBZ_CHUNK +: CBZ_CHUNK]));
         end
         pp_in[k] = ma * mt;
      end
   end

   always_comb begin
      logic signed [SW-1:0] acc;
      acc = SW'(a2_ff) <<< T_FRAC_BITS;
      for (int k = 0; k < NCH; k++) begin
         acc = acc + (SW'(pp_ff[k]) <<< (k * CBZ_CHUNK));
      end
      y_in = $signed(acc[OW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         diff_ff <= diff_in;
         a1_ff   <= a_val;
         t1_ff   <= t_in;
      end
      if (en[1]) begin
         pp_ff <= pp_in;
         a2_ff <= a1_ff;
      end
      if (en[2]) begin
         y_ff <= y_in;
      end
   end

   assign y_val = y_ff;

endmodule

FILE: design/cbz_axis.sv
// One coordinate axis: row of lerp cells, derivative and output rounding.
`timescale 1ns / 1ps
module cbz_axis #(
   parameter int COORD_WIDTH = 24,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  cbz_pkg::stage_en_type         en,
   input  logic signed [COORD_WIDTH-1:0] p0,
   input  logic signed [COORD_WIDTH-1:0] p1,
   input  logic signed [COORD_WIDTH-1:0] p2,
   input  logic signed [COORD_WIDTH-1:0] p3,
   input  logic [T_FRAC_BITS:0]          t_in,
   output logic signed [COORD_WIDTH-1:0] point,
   output logic signed [COORD_WIDTH+2:0] slope
);
   import cbz_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int F    = T_FRAC_BITS;
   localparam int W1   = W + F;
   localparam int W2   = W + 2 * F;
   localparam int W3   = W + 3 * F;
   localparam int DW3  = W2 + 3;
   localparam int PRW  = W3 + 1;
   localparam logic signed [DW3-1:0] SLOPE_HALF = DW3'(1) <<< (2 * F - 1);
   localparam logic signed [PRW-1:0] POINT_HALF = PRW'(1) <<< (3 * F - 1);

   logic signed [W-1:0]  pv [4];
   logic signed [W1-1:0] y1 [3];
   logic signed [W2-1:0] y2 [2];
   logic signed [W3-1:0] y3;
   logic [F:0]           tq_ff [6];

   logic signed [DW3-1:0] d3_ff, d3_in;
   logic signed [W+2:0]   srnd_ff, srnd_in;
   logic signed [W+2:0]   shold_ff;
   logic signed [W+2:0]   slope_ff;
   logic signed [W-1:0]   point_ff, point_in;

   assign pv[0] = p0;
   assign pv[1] = p1;
   assign pv[2] = p2;
   assign pv[3] = p3;

   // Carry t alongside the cells so each level sees the parameter of its request
   always_ff @(posedge clock) begin
      if (en[1]) tq_ff[0] <= t_in;
      for (int s = 1; s < 6; s++) begin
         if (en[s+1]) tq_ff[s] <= tq_ff[s-1];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lvl1
      cbz_lerp_cell #(.IN_W(W), .T_FRAC_BITS(F)) u_cell (
         .clock (clock),
         .en    (en[3:1]),
         .a_val (pv[i]),
         .b_val (pv[i+1]),
         .t_in  (t_in),
         .y_val (y1[i])
      );
   end

   for (genvar i = 0; i < 2; i++) begin : g_lvl2
      cbz_lerp_cell #(.IN_W(W1), .T_FRAC_BITS(F)) u_cell (
         .clock (clock),
         .en    (en[6:4]),
         .a_val (y1[i]),
         .b_val (y1[i+1]),
         .t_in  (tq_ff[2]),
         .y_val (y2[i])
      );
   end

   cbz_lerp_cell #(.IN_W(W2), .T_FRAC_BITS(F)) u_lvl3 (
      .clock (clock),
      .en    (en[9:7]),
      .a_val (y2[0]),
      .b_val (y2[1]),
      .t_in  (tq_ff[5]),
      .y_val (y3)
   );

   // Tangent: three times the difference of the second-level points
   always_comb begin
      logic signed [DW3-1:0] dd;
      logic signed [DW3-1:0] rs;
      logic signed [PRW-1:0] pr;
      dd       = DW3'(y2[1]) - DW3'(y2[0]);
      d3_in    = dd + (dd <<< 1);
      rs       = d3_ff + SLOPE_HALF;
      srnd_in  = $signed(rs[2*F +: W+3]);
      pr       = PRW'(y3) + POINT_HALF;
      point_in = $signed(pr[3*F +: W]);
   end

   always_ff @(posedge clock) begin
      if (en[7])  d3_ff    <= d3_in;
      if (en[8])  srnd_ff  <= srnd_in;
      if (en[9])  shold_ff <= srnd_ff;
      if (en[10]) begin
         slope_ff <= shold_ff;
         point_ff <= point_in;
      end
   end

   assign point = point_ff;
   assign slope = slope_ff;

endmodule

FILE: design/cubic_bezier_point_and_tangent_top.sv
// Top level of the cubic Bezier point and tangent evaluator.
//
// Usage: write the four control points (x and y of P0..P3, signed, 8 fraction
// bits) through the csr_ APB port while no request is in flight. Each request
// on req_ch carries t_param (16 fraction bits, 1.0 = 65536; larger values are
// taken as 1.0). Each request yields one response on rsp_ch with the curve
// point and the derivative dB/dt, both rounded to nearest, ties upwards.
// Each request passes the input register, three levels of three-stage lerp
// cells and the output register before its response appears. Throughput: one
// request per cycle, unless rsp_ch.ready is low and the pipeline is full.
// Stalls: when rsp_ch.ready is low the response holds; earlier stages keep
// advancing into empty slots, so requests are still taken until the pipeline
// is full. Reset clears all in-flight requests and the control points to 0.
`timescale 1ns / 1ps
module cubic_bezier_point_and_tangent_top #(
   parameter int  COORD_WIDTH = cbz_pkg::CBZ_COORD_WIDTH,
   parameter int  T_FRAC_BITS = cbz_pkg::CBZ_T_FRAC_BITS,
   localparam int CSR_DW      = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int CSR_LSB     = (COORD_WIDTH > 32) ? 3 : 2,
   localparam int CSR_AW      = CSR_LSB + 3
) (
   input  logic              clock,
   input  logic              reset,
   cbz_req_if.sink           req_ch,
   cbz_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   import cbz_pkg::*;

   localparam int NS = CBZ_STAGES;
   localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

   logic [COORD_WIDTH-1:0] csr_ff [CBZ_NUM_REGS];
   logic [2:0]             csr_idx;
   logic                   csr_wr;

   logic [NS-1:0]          v_ff, v_in;
   stage_en_type           stage_en;
   logic [T_FRAC_BITS:0]   t_ff, t_in;

   // Register file
   assign csr_idx    = csr_paddr[CSR_AW-1:CSR_LSB];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DW'(csr_ff[csr_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CBZ_NUM_REGS; i++) csr_ff[i] <= '0;
      end else if (csr_wr) begin
         csr_ff[csr_idx] <= csr_pwdata[COORD_WIDTH-1:0];
      end
   end

   // Stage enables: a stage advances when it is empty or its successor advances
   always_comb begin
      stage_en[NS-1] = ~v_ff[NS-1] | rsp_ch.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         stage_en[k] = ~v_ff[k] | stage_en[k+1];
      end
   end

   always_comb begin
      v_in[0] = stage_en[0] ? req_ch.valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = stage_en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Clamp t to one on the way in
   assign t_in = (req_ch.t_param > T_ONE) ? T_ONE : req_ch.t_param;

   always_ff @(posedge clock) begin
      if (stage_en[0]) t_ff <= t_in;
   end

   assign req_ch.ready = stage_en[0];
   assign rsp_ch.valid = v_ff[NS-1];

   cbz_axis #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_axis_x (
      .clock (clock),
      .en    (stage_en),
      .p0    ($signed(csr_ff[REG_P0_X])),
      .p1    ($signed(csr_ff[REG_P1_X])),
      .p2    ($signed(csr_ff[REG_P2_X])),
      .p3    ($signed(csr_ff[REG_P3_X])),
      .t_in  (t_ff),
      .point (rsp_ch.point_x),
      .slope (rsp_ch.slope_x)
   );

   cbz_axis #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_axis_y (
      .clock (clock),
      .en    (stage_en),
      .p0    ($signed(csr_ff[REG_P0_Y])),
      .p1    ($signed(csr_ff[REG_P1_Y])),
      .p2    ($signed(csr_ff[REG_P2_Y])),
      .p3    ($signed(csr_ff[REG_P3_Y])),
      .t_in  (t_ff),
      .point (rsp_ch.point_y),
      .slope (rsp_ch.slope_y)
   );

endmodule

FILE: design/cbz_checker.sv
// Port-level checks on the Bezier evaluator, bound to its top level.
`timescale 1ns / 1ps
module cbz_checker #(
   parameter int COORD_WIDTH = 24,
   parameter int DEPTH       = 11
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COORD_WIDTH-1:0] rsp_point_x,
   input logic [COORD_WIDTH+2:0] rsp_slope_x
);
   localparam int CW = $clog2(DEPTH + 2) + 1;

   logic [CW-1:0] cnt_ff;

   // Requests taken but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + CW'(req_valid & req_ready) - CW'(rsp_valid & rsp_ready);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x) && $stable(rsp_slope_x))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("response without an outstanding request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("more requests in flight than pipeline stages");

   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while output drains");

endmodule

bind cubic_bezier_point_and_tangent_top cbz_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .DEPTH       (cbz_pkg::CBZ_STAGES)
) u_cbz_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_point_x (rsp_ch.point_x),
   .rsp_slope_x (rsp_ch.slope_x)
);

FILE: tb/sv/tb_cubic_bezier_point_and_tangent_top.sv
// Self-checking testbench for the cubic Bezier point and tangent evaluator.
`timescale 1ns / 1ps
module tb_cubic_bezier_point_and_tangent_top;
   import cbz_pkg::*;

   localparam int CSR_AW        = 5;
   localparam int CSR_DW        = 32;
   localparam int T_W           = CBZ_T_FRAC_BITS + 1;
   localparam int PIPE_LATENCY  = CBZ_STAGES - 1;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_ITEMS   = 108;
   localparam int RANDOM_PHASES = 6;

   localparam logic signed [CBZ_COORD_WIDTH-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [CBZ_COORD_WIDTH-1:0] COORD_MIN = 24'sh800000;
   localparam logic signed [95:0] T_ONE      = 96'sd1 <<< CBZ_T_FRAC_BITS;
   localparam logic signed [95:0] POINT_HALF = 96'sd1 <<< (3 * CBZ_T_FRAC_BITS - 1);
   localparam logic signed [95:0] SLOPE_HALF = 96'sd1 <<< (2 * CBZ_T_FRAC_BITS - 1);

   typedef logic signed [CBZ_COORD_WIDTH-1:0] coord_type;
   typedef logic signed [CBZ_COORD_WIDTH+2:0] slope_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      slope_type slope_x;
      slope_type slope_y;
   } curve_sample_type;

   // Exact de Casteljau evaluation of one axis, rounded once at the end
   function automatic void eval_axis(input coord_type c0, input coord_type c1,
                                     input coord_type c2, input coord_type c3,
                                     input logic signed [95:0] rr,
                                     input logic signed [95:0] tt, output coord_type pt,
                                     output slope_type sl);
      logic signed [95:0] p0, p1, p2, p3, a0, a1, a2, b0, b1, cc, d3, rp, rs;
      p0 = c0;
      p1 = c1;
      p2 = c2;
      p3 = c3;
      a0 = rr * p0 + tt * p1;
      a1 = rr * p1 + tt * p2;
      a2 = rr * p2 + tt * p3;
      b0 = rr * a0 + tt * a1;
      b1 = rr * a1 + tt * a2;
      cc = rr * b0 + tt * b1;
      d3 = 3 * (b1 - b0);
      rp = (cc + POINT_HALF) >>> (3 * CBZ_T_FRAC_BITS);
      rs = (d3 + SLOPE_HALF) >>> (2 * CBZ_T_FRAC_BITS);
      pt = rp[CBZ_COORD_WIDTH-1:0];
      sl = rs[CBZ_COORD_WIDTH+2:0];
   endfunction

   class bezier_scoreboard;
      coord_type        ctrl[CBZ_NUM_REGS];
      curve_sample_type expected_samples[$];
      int               errors;

      function new();
         foreach (ctrl[i]) ctrl[i] = '0;
         errors = 0;
      endfunction

      function void set_point(csr_reg_type idx, coord_type value);
         ctrl[idx] = value;
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      task report_mismatch(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function curve_sample_type predict_sample(logic [T_W-1:0] t_raw);
         logic signed [95:0] tt, rr;
         coord_type          px, py;
         slope_type          sx, sy;
         curve_sample_type   s;
         // saturate anything above one
         if (t_raw > T_ONE) tt = T_ONE;
         else tt = {{(96 - T_W) {1'b0}}, t_raw};
         rr = T_ONE - tt;
         eval_axis(ctrl[REG_P0_X], ctrl[REG_P1_X], ctrl[REG_P2_X], ctrl[REG_P3_X],
                   rr, tt, px, sx);
         eval_axis(ctrl[REG_P0_Y], ctrl[REG_P1_Y], ctrl[REG_P2_Y], ctrl[REG_P3_Y],
                   rr, tt, py, sy);
         s.point_x = px;
         s.point_y = py;
         s.slope_x = sx;
         s.slope_y = sy;
         return s;
      endfunction

      function void note_request(logic [T_W-1:0] t_raw);
         expected_samples.insert(expected_samples.size(), predict_sample(t_raw));
      endfunction

      task check_response(input coord_type px, input coord_type py, input slope_type sx,
                          input slope_type sy);
         curve_sample_type e;
         if (expected_samples.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            e = expected_samples.pop_front();
            if (px !== e.point_x)
               report_mismatch($sformatf("point_x got %0d want %0d", px, e.point_x));
            if (py !== e.point_y)
               report_mismatch($sformatf("point_y got %0d want %0d", py, e.point_y));
            if (sx !== e.slope_x)
               report_mismatch($sformatf("slope_x got %0d want %0d", sx, e.slope_x));
            if (sy !== e.slope_y)
               report_mismatch($sformatf("slope_y got %0d want %0d", sy, e.slope_y));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   cbz_req_if #(.T_W(T_W)) req_ch ();
   cbz_rsp_if #(.COORD_W(CBZ_COORD_WIDTH)) rsp_ch ();

   cubic_bezier_point_and_tangent_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bezier_scoreboard sb;
   coord_type        cfg_points[CBZ_NUM_REGS];
   bit               calm        = 1'b0;
   bit               pressure_go = 1'b0;
   int               hold_count  = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Record accepted requests and check responses
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) sb.note_request(req_ch.t_param);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response(rsp_ch.point_x, rsp_ch.point_y, rsp_ch.slope_x, rsp_ch.slope_y);
   end

   // Response side: random back-pressure, one long hold-off to fill the pipeline
   always @(posedge clock) begin
      if (pressure_go && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_ch.ready <= 1'b0;
      end else if (calm) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= 17);
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_MAX) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog expired after %0d idle cycles", WATCHDOG_MAX);
      $display("[cubic_bezier_point_and_tangent_top] ERROR");
      $finish;
   end

   task automatic csr_transfer(input bit is_write, input int idx, input logic [CSR_DW-1:0] wdata,
                               output logic [CSR_DW-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_AW'(idx << 2);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      // sample mid-cycle, away from the driving edge
      do @(negedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_points();
      logic [CSR_DW-1:0] rdata;
      for (int i = 0; i < CBZ_NUM_REGS; i++) begin
         // junk in the upper bits must be dropped
         csr_transfer(1'b1, i, {8'($urandom), cfg_points[i]}, rdata);
         sb.set_point(csr_reg_type'(i), cfg_points[i]);
      end
      for (int i = 0; i < CBZ_NUM_REGS; i++) begin
         csr_transfer(1'b0, i, '0, rdata);
         if (rdata[CBZ_COORD_WIDTH-1:0] !== cfg_points[i])
            sb.report_mismatch($sformatf("register %0d read back %0h want %0h",
                               i, rdata[CBZ_COORD_WIDTH-1:0], cfg_points[i]));
      end
   endtask

   task automatic send_request(input logic [T_W-1:0] t);
      // idle a cycle at a time, roughly one cycle in six
      while (!calm && $urandom_range(99) < 17) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.t_param <= t;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drain outstanding responses, then let the pipeline settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   function automatic logic [T_W-1:0] pick_t_param();
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) return '0;
      if (roll < 8) return T_W'(T_ONE);
      if (roll < 20) return T_W'($urandom_range((1 << T_W) - 1, (1 << CBZ_T_FRAC_BITS) + 1));
      return T_W'($urandom_range(1 << CBZ_T_FRAC_BITS));
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(9))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         default: return coord_type'($urandom);
      endcase
   endfunction

   initial begin
      logic [T_W-1:0] reset_ts[4];
      logic [T_W-1:0] corner_ts[12];
      reset_ts  = '{17'h00000, 17'h08000, 17'h10000, 17'h1FFFF};
      corner_ts = '{17'h00000, 17'h00001, 17'h04000, 17'h08000, 17'h08001, 17'h0C000,
                    17'h0FFFF, 17'h10000, 17'h10001, 17'h18000, 17'h1FFFF, 17'h05555};
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.t_param = '0;
      rsp_ch.ready   = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // control points still at their reset value
      foreach (reset_ts[i]) send_request(reset_ts[i]);
      wait_drained();

      // opposite extremes on alternate points: largest derivative
      cfg_points[REG_P0_X] = COORD_MAX;
      cfg_points[REG_P1_X] = COORD_MIN;
      cfg_points[REG_P2_X] = COORD_MAX;
      cfg_points[REG_P3_X] = COORD_MIN;
      cfg_points[REG_P0_Y] = COORD_MIN;
      cfg_points[REG_P1_Y] = COORD_MAX;
      cfg_points[REG_P2_Y] = COORD_MIN;
      cfg_points[REG_P3_Y] = COORD_MAX;
      load_points();
      foreach (corner_ts[i]) send_request(corner_ts[i]);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int i = 0; i < CBZ_NUM_REGS; i++) begin
            if (phase == 0) cfg_points[i] = COORD_MAX;
            else if (phase == 1) cfg_points[i] = COORD_MIN;
            else cfg_points[i] = pick_coord();
         end
         load_points();
         if (phase == 2) pressure_go = 1'b1;
         calm = (phase == 3);
         repeat (PHASE_ITEMS) send_request(pick_t_param());
         calm = 1'b0;
         wait_drained();
      end

      if (sb.errors == 0) begin
         $display("[cubic_bezier_point_and_tangent_top] OK");
      end else begin
         $display("[cubic_bezier_point_and_tangent_top] ERROR");
      end
      $finish;
   end

endmodule
